// ===== sv/awfbt_pkg.sv =====
// shared types and operation codes for the alu with flags and branch test
package awfbt_pkg;

	localparam int unsigned DATA_WIDTH_DEF = 64;
	localparam int unsigned FIELD_WIDTH    = 64;
	localparam int unsigned MODE_WIDTH     = 5;

	typedef enum logic [MODE_WIDTH-1:0] {
		MODE_ADD  = 5'd0,
		MODE_SUB  = 5'd1,
		MODE_MUL  = 5'd2,
		MODE_DIV  = 5'd3,
		MODE_MOD  = 5'd4,
		MODE_AND  = 5'd5,
		MODE_OR   = 5'd6,
		MODE_XOR  = 5'd7,
		MODE_SHL  = 5'd8,
		MODE_SHR  = 5'd9,
		MODE_SAR  = 5'd10,
		MODE_NEG  = 5'd11,
		MODE_NOT  = 5'd12,
		MODE_PASS = 5'd13,
		MODE_JEQ  = 5'd14,
		MODE_JNE  = 5'd15,
		MODE_JLT  = 5'd16,
		MODE_JLE  = 5'd17,
		MODE_JGT  = 5'd18,
		MODE_JGE  = 5'd19
	} mode_t;

	typedef struct packed {
		logic [MODE_WIDTH-1:0]  mode;
		logic [FIELD_WIDTH-1:0] lhs;
		logic [FIELD_WIDTH-1:0] rhs;
	} req_t;

	typedef struct packed {
		logic [FIELD_WIDTH-1:0] result;
		logic                   zero_flag;
		logic                   negative_flag;
		logic                   carry_flag;
		logic                   overflow_flag;
		logic                   branch_taken;
		logic                   divide_error;
	} rsp_t;

endpackage

// ===== sv/awfbt_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with a side tag
module awfbt_div #(
	parameter int unsigned W     = awfbt_pkg::DATA_WIDTH_DEF,
	parameter int unsigned TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [W-1:0]     dividend,
	input  logic [W-1:0]     divisor,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_valid,
	output logic [W-1:0]     quotient,
	output logic [W-1:0]     remainder,
	output logic [TAG_W-1:0] tag_out
);

	logic             vld_s [0:W];
	logic [W-1:0]     rem_s [0:W];
	logic [W-1:0]     dvd_s [0:W];
	logic [W-1:0]     dsr_s [0:W];
	logic [TAG_W-1:0] tag_s [0:W];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign dvd_s[0] = dividend;
	assign dsr_s[0] = divisor;
	assign tag_s[0] = tag_in;

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W:0] trial;
		logic       qbit;

		always_comb begin
			trial = {rem_s[k], dvd_s[k][W-1]} - {1'b0, dsr_s[k]};
			qbit  = ~trial[W];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= qbit ? trial[W-1:0] : {rem_s[k][W-2:0], dvd_s[k][W-1]};
			dvd_s[k+1] <= {dvd_s[k][W-2:0], qbit};
			dsr_s[k+1] <= dsr_s[k];
			tag_s[k+1] <= tag_s[k];
		end
	end

	assign out_valid = vld_s[W];
	assign quotient  = dvd_s[W];
	assign remainder = rem_s[W];
	assign tag_out   = tag_s[W];

endmodule

// ===== sv/alu_with_flags_and_branch_test.sv =====
// top level: pipelined alu with nzcv flags, compare-branch test and signed divide
// a start transfer passes the input, stage 2 and stage 3 registers, the divider stages and the output register
// throughput: one transfer per cycle, busy stays low; the divider has one stage per bit
// the receiver cannot stall, every result shows on rsp for exactly one cycle
// reset clears all valid bits, so no done strobe follows reset until a new transfer
module alu_with_flags_and_branch_test #(
	parameter int unsigned DATA_WIDTH = awfbt_pkg::DATA_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  awfbt_pkg::req_t   req,
	output logic              done,
	output awfbt_pkg::rsp_t   rsp
);

	localparam int unsigned W     = DATA_WIDTH;
	localparam int unsigned LW    = W / 2;
	localparam int unsigned HW    = W - LW;
	localparam int unsigned TAG_W = W + 9;

	// stage 1: input register
	logic             vld_s1;
	awfbt_pkg::mode_t mode_s1;
	logic [W-1:0]     a_s1;
	logic [W-1:0]     b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= awfbt_pkg::mode_t'(req.mode);
		a_s1    <= req.lhs[W-1:0];
		b_s1    <= req.rhs[W-1:0];
	end

	assign busy = 1'b0;

	// stage 2: simple ops, operand magnitudes, partial products
	logic [W:0]   sum_w;
	logic [W:0]   dif_w;
	logic [W-1:0] res_c;
	logic         c_c, v_c, br_c, zall_c, err_c, isdiv_c, ismod_c, ismul_c;
	logic         lt_c, eq_c, na_c, nb_c;

	always_comb begin
		sum_w   = {1'b0, a_s1} + {1'b0, b_s1};
		dif_w   = {1'b0, a_s1} - {1'b0, b_s1};
		eq_c    = (a_s1 == b_s1);
		lt_c    = ($signed(a_s1) < $signed(b_s1));
		na_c    = a_s1[W-1];
		nb_c    = b_s1[W-1];
		res_c   = '0;
		c_c     = 1'b0;
		v_c     = 1'b0;
		br_c    = 1'b0;
		zall_c  = 1'b0;
		err_c   = 1'b0;
		isdiv_c = 1'b0;
		ismod_c = 1'b0;
		ismul_c = 1'b0;
		unique case (mode_s1)
			awfbt_pkg::MODE_ADD: begin
				res_c = sum_w[W-1:0];
				c_c   = sum_w[W];
				v_c   = (a_s1[W-1] ^ sum_w[W-1]) & (b_s1[W-1] ^ sum_w[W-1]);
			end
			awfbt_pkg::MODE_SUB: begin
				res_c = dif_w[W-1:0];
				c_c   = dif_w[W];
				v_c   = (a_s1[W-1] ^ b_s1[W-1]) & (a_s1[W-1] ^ dif_w[W-1]);
			end
			awfbt_pkg::MODE_MUL: ismul_c = 1'b1;
			awfbt_pkg::MODE_DIV, awfbt_pkg::MODE_MOD: begin
				isdiv_c = (mode_s1 == awfbt_pkg::MODE_DIV);
				ismod_c = (mode_s1 == awfbt_pkg::MODE_MOD);
				err_c   = (b_s1 == '0);
				zall_c  = err_c;
			end
			awfbt_pkg::MODE_AND:  res_c = a_s1 & b_s1;
			awfbt_pkg::MODE_OR:   res_c = a_s1 | b_s1;
			awfbt_pkg::MODE_XOR:  res_c = a_s1 ^ b_s1;
			awfbt_pkg::MODE_SHL:  res_c = a_s1 << b_s1[5:0];
			awfbt_pkg::MODE_SHR:  res_c = a_s1 >> b_s1[5:0];
			awfbt_pkg::MODE_SAR:  res_c = W'($signed(a_s1) >>> b_s1[5:0]);
			awfbt_pkg::MODE_NEG:  res_c = W'(0) - a_s1;
			awfbt_pkg::MODE_NOT:  res_c = ~a_s1;
			awfbt_pkg::MODE_PASS: res_c = a_s1;
			awfbt_pkg::MODE_JEQ, awfbt_pkg::MODE_JNE, awfbt_pkg::MODE_JLT,
			awfbt_pkg::MODE_JLE, awfbt_pkg::MODE_JGT, awfbt_pkg::MODE_JGE: begin
				res_c = dif_w[W-1:0];
				c_c   = dif_w[W];
				v_c   = (a_s1[W-1] ^ b_s1[W-1]) & (a_s1[W-1] ^ dif_w[W-1]);
				unique case (mode_s1)
					awfbt_pkg::MODE_JEQ: br_c = eq_c;
					awfbt_pkg::MODE_JNE: br_c = ~eq_c;
					awfbt_pkg::MODE_JLT: br_c = lt_c;
					awfbt_pkg::MODE_JLE: br_c = lt_c | eq_c;
					awfbt_pkg::MODE_JGT: br_c = ~lt_c & ~eq_c;
					default:             br_c = ~lt_c;
				endcase
			end
			default: zall_c = 1'b1;
		endcase
	end

	logic              vld_s2;
	logic [W-1:0]      res_s2;
	logic              c_s2, v_s2, br_s2, zall_s2, err_s2, isdiv_s2, ismod_s2, ismul_s2;
	logic              na_s2, nb_s2;
	logic [W-1:0]      ua_s2, ub_s2;
	logic [2*LW-1:0]   ll_s2;
	logic [LW+HW-1:0]  lh_s2, hl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		res_s2   <= res_c;
		c_s2     <= c_c;
		v_s2     <= v_c;
		br_s2    <= br_c;
		zall_s2  <= zall_c;
		err_s2   <= err_c;
		isdiv_s2 <= isdiv_c;
		ismod_s2 <= ismod_c;
		ismul_s2 <= ismul_c;
		na_s2    <= na_c;
		nb_s2    <= nb_c;
		ua_s2    <= na_c ? (W'(0) - a_s1) : a_s1;
		ub_s2    <= nb_c ? (W'(0) - b_s1) : b_s1;
		ll_s2    <= a_s1[LW-1:0] * b_s1[LW-1:0];
		lh_s2    <= a_s1[LW-1:0] * b_s1[W-1:LW];
		hl_s2    <= a_s1[W-1:LW] * b_s1[LW-1:0];
	end

	// stage 3: product assembly
	logic [W-1:0] cross_c;
	logic [W-1:0] mul_c;

	always_comb begin
		cross_c = W'(lh_s2) + W'(hl_s2);
		mul_c   = W'(ll_s2) + (cross_c << LW);
	end

	logic             vld_s3;
	logic [W-1:0]     ua_s3, ub_s3;
	logic [TAG_W-1:0] tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ua_s3  <= ua_s2;
		ub_s3  <= ub_s2;
		tag_s3 <= {ismul_s2 ? mul_c : res_s2, c_s2, v_s2, br_s2, zall_s2, err_s2,
		           isdiv_s2, ismod_s2, na_s2, nb_s2};
	end

	// divider stages
	logic             dvld;
	logic [W-1:0]     quo;
	logic [W-1:0]     rmd;
	logic [TAG_W-1:0] tag_d;

	awfbt_div #(
		.W     (W),
		.TAG_W (TAG_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.dividend  (ua_s3),
		.divisor   (ub_s3),
		.tag_in    (tag_s3),
		.out_valid (dvld),
		.quotient  (quo),
		.remainder (rmd),
		.tag_out   (tag_d)
	);

	// final stage: sign fix, select, flags
	logic [W-1:0] t_res;
	logic         t_c, t_v, t_br, t_zall, t_err, t_div, t_mod, t_na, t_nb;
	logic [W-1:0] fin;
	awfbt_pkg::rsp_t rsp_c;

	always_comb begin
		{t_res, t_c, t_v, t_br, t_zall, t_err, t_div, t_mod, t_na, t_nb} = tag_d;
		priority if (t_div) begin
			fin = (t_na ^ t_nb) ? (W'(0) - quo) : quo;
		end else if (t_mod) begin
			fin = t_na ? (W'(0) - rmd) : rmd;
		end else begin
			fin = t_res;
		end
		if (t_zall) begin
			rsp_c = '0;
		end else begin
			rsp_c.result        = awfbt_pkg::FIELD_WIDTH'(fin);
			rsp_c.zero_flag     = (fin == '0);
			rsp_c.negative_flag = fin[W-1];
			rsp_c.carry_flag    = t_c;
			rsp_c.overflow_flag = t_v;
			rsp_c.branch_taken  = t_br;
			rsp_c.divide_error  = 1'b0;
		end
		rsp_c.divide_error = t_err;
	end

	logic            done_q;
	awfbt_pkg::rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dvld;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_c;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
